// ===== design/assert_macros.svh =====
// assertion helper macros for the carriage tracker
// no dependencies, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent on one edge implies consequent on the next
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/npt_pkg.sv =====
// shared types and constants for the needle position tracker
// no dependencies
`timescale 1ns / 1ps

package npt_pkg;

    localparam int POS_W = 16;
    localparam int IDX_W = 8;

    // command codes
    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic signed [POS_W-1:0] POS_RESET = -16'sd50;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic [IDX_W-1:0]        needle_index;
        logic                    moving_left;
        logic                    moved;
    } res_t;

endpackage

// ===== design/needle_position_tracker.sv =====
// needle position tracker: quadrature decode with belt phase correction
// depends on npt_pkg and assert_macros.svh
`timescale 1ns / 1ps
// an accepted beat's result is registered in the output register or the skid entry
// throughput: one beat per cycle while the skid entry is empty
// output register plus one skid entry, so the skid entry takes one more beat
// when the output side stalls
// reset: position -50, direction right, phase and calibration cleared
`include "assert_macros.svh"

module needle_position_tracker #(
    parameter int NEEDLES     = 200,
    parameter int BELT_PERIOD = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            command,
    input  logic                            v1_level,
    input  logic                            v2_level,
    input  logic                            belt_level,
    input  logic signed [npt_pkg::POS_W-1:0] new_position,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [npt_pkg::POS_W-1:0] position,
    output logic [npt_pkg::IDX_W-1:0]       needle_index,
    output logic                            moving_left,
    output logic                            moved
);
    import npt_pkg::*;

    // phase distance width, one extra bit for the modular sum
    localparam int PDW = $clog2(BELT_PERIOD);
    localparam logic [PDW:0]       PERIOD_X  = (PDW + 1)'(BELT_PERIOD);
    localparam logic [PDW-1:0]     PD_LAST   = PDW'(BELT_PERIOD - 1);
    localparam logic [PDW-1:0]     PD_ONE    = PDW'(1);
    localparam logic [PDW-1:0]     PD_HALF   = PDW'(BELT_PERIOD / 2);
    localparam logic [POS_W-1:0]   PERIOD_P  = POS_W'(BELT_PERIOD);
    localparam logic [POS_W-1:0]   IDX_MAX   = POS_W'(NEEDLES - 1);

    // both operands are below the period, so one compare and subtract
    function automatic logic [PDW-1:0] phase_add(input logic [PDW-1:0] d,
                                                 input logic [PDW-1:0] k);
        logic [PDW:0] s;
        s = {1'b0, d} + {1'b0, k};
        if (s >= PERIOD_X)
            s = s - PERIOD_X;
        return s[PDW-1:0];
    endfunction

    // tracker state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             dir_left_reg, dir_left_next;
    logic             prev_v2_reg, prev_v2_next;
    logic [PDW-1:0]   phase_reg, phase_next;
    logic             prev_belt_reg, prev_belt_next;
    logic             calibrated_reg, calibrated_next;

    // output register and skid entry
    res_t out_reg, skid_reg;
    logic out_valid_reg, skid_valid_reg;

    logic accept_in;
    logic pop_out;
    res_t res_new;

    // combinational update terms
    logic             step_moved;
    logic [POS_W-1:0] pos_step;
    logic [PDW-1:0]   pd_step;
    logic [PDW-1:0]   pd_shift;
    logic [PDW-1:0]   pd_err;
    logic [POS_W-1:0] delta;
    logic             raising;

    // the skid entry is the only thing that holds off the input side
    assign in_stall  = skid_valid_reg;
    assign accept_in = in_valid && !in_stall;
    assign pop_out   = out_valid_reg && !out_stall;

    always_comb
    begin
        pos_next        = pos_reg;
        dir_left_next   = dir_left_reg;
        prev_v2_next    = prev_v2_reg;
        phase_next      = phase_reg;
        prev_belt_next  = prev_belt_reg;
        calibrated_next = calibrated_reg;
        step_moved      = 1'b0;

        // direction follows the new v2 edge, step uses that direction
        dir_left_next = (v1_level == v2_level);
        pos_step = dir_left_next ? (pos_reg - POS_W'(1)) : (pos_reg + POS_W'(1));
        pd_step  = phase_add(phase_reg, dir_left_next ? PD_LAST : PD_ONE);
        raising  = dir_left_next != belt_level;
        pd_shift = raising ? pd_step : phase_add(pd_step, PD_HALF);
        pd_err   = phase_add(pd_shift, dir_left_next ? PD_ONE : '0);
        // signed phase error, wrapped into the upper half as negative
        delta    = (pd_err <= PD_HALF) ? POS_W'(pd_err) : (POS_W'(pd_err) - PERIOD_P);

        if (command == CMD_LOAD)
        begin
            pos_next      = new_position;
            dir_left_next = dir_left_reg;
        end
        else if (v2_level != prev_v2_reg)
        begin
            prev_v2_next = v2_level;
            if (v2_level)
            begin
                step_moved = 1'b1;
                pos_next   = pos_step;
                phase_next = pd_step;
                if (belt_level != prev_belt_reg)
                begin
                    // first belt edge only calibrates, without correcting the position
                    if (calibrated_reg)
                        pos_next = pos_step - delta;
                    calibrated_next = 1'b1;
                    prev_belt_next  = belt_level;
                    // re-base the phase, half period off when the belt level matches the direction bit
                    phase_next = dir_left_next ? PD_LAST : '0;
                    if (!raising)
                        phase_next = phase_add(phase_next, PD_HALF);
                end
            end
        end
        else
        begin
            dir_left_next = dir_left_reg;
        end
    end

    // result beat from the updated state
    always_comb
    begin
        res_new.position    = pos_next;
        res_new.moving_left = dir_left_next;
        res_new.moved       = step_moved;
        if (pos_next[POS_W-1])
            res_new.needle_index = '0;
        else if (pos_next > IDX_MAX)
            res_new.needle_index = IDX_MAX[IDX_W-1:0];
        else
            res_new.needle_index = pos_next[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= POS_RESET;
            dir_left_reg   <= 1'b0;
            prev_v2_reg    <= 1'b0;
            phase_reg      <= '0;
            prev_belt_reg  <= 1'b0;
            calibrated_reg <= 1'b0;
        end
        else if (accept_in)
        begin
            pos_reg        <= pos_next;
            dir_left_reg   <= dir_left_next;
            prev_v2_reg    <= prev_v2_next;
            phase_reg      <= phase_next;
            prev_belt_reg  <= prev_belt_next;
            calibrated_reg <= calibrated_next;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop_out)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept_in;
            end
        end
        else if (accept_in)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop_out)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept_in)
                out_reg <= res_new;
        end
        else if (accept_in)
        begin
            skid_reg <= res_new;
        end
    end

    assign out_valid    = out_valid_reg;
    assign position     = out_reg.position;
    assign needle_index = out_reg.needle_index;
    assign moving_left  = out_reg.moving_left;
    assign moved        = out_reg.moved;

    // checks on internal bookkeeping
    `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg, "skid full with empty output")
    `ASSERT_ALWAYS(a_phase_range, {1'b0, phase_reg} < PERIOD_X, "phase distance out of range")
    `ASSERT_NEXT(a_load_keeps_phase, accept_in && command == CMD_LOAD, $stable(phase_reg) && $stable(dir_left_reg) && $stable(calibrated_reg), "load changed tracker state")
    `ASSERT_NEXT(a_calibrated_sticks, calibrated_reg, calibrated_reg, "calibration lost")

endmodule
